// ===== hw/rtl/tdpt_pkg.sv =====
package tdpt_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_div;
        logic res_load;
        logic res_value;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic bound_exceeded;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/tdpt_dp.sv =====
module tdpt_dp #(
    parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH,
    localparam int IN_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IN_W-1:0] i_s_tdata,
    input  tdpt_pkg::t_cmd  i_cmd,
    output tdpt_pkg::t_sts  o_sts,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_d;
    logic [VALUE_WIDTH:0]   r_sq;
    logic [VALUE_WIDTH-1:0] r_shift;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_valid;
    logic                   r_res;

    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH:0]   w_diff;
    logic [VALUE_WIDTH-1:0] n_rem;

    assign w_trial = {r_rem, r_shift[VALUE_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign n_rem   = (w_trial >= {1'b0, r_d}) ? w_diff[VALUE_WIDTH-1:0]
                                              : w_trial[VALUE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n  <= i_s_tdata[VALUE_WIDTH-1:0];
            r_d  <= VALUE_WIDTH'(2);
            r_sq <= (VALUE_WIDTH + 1)'(4);
        end else if (i_cmd.next_div) begin
            r_d  <= r_d + VALUE_WIDTH'(1);
            r_sq <= r_sq + {r_d, 1'b1};
        end
        if (i_cmd.div_start) begin
            r_shift <= r_n;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.div_step) begin
            r_shift <= {r_shift[VALUE_WIDTH-2:0], 1'b0};
            r_rem   <= n_rem;
            r_cnt   <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.res_load) begin
            r_res <= i_cmd.res_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.trivial        = r_n[VALUE_WIDTH-1] || (r_n <= VALUE_WIDTH'(1));
    assign o_sts.bound_exceeded = r_sq > {1'b0, r_n};
    assign o_sts.div_last       = r_cnt == CNT_W'(VALUE_WIDTH - 1);
    assign o_sts.rem_zero       = r_rem == '0;
    assign o_sts.out_free       = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_res};

endmodule

// ===== hw/rtl/tdpt_ctrl.sv =====
module tdpt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  tdpt_pkg::t_sts i_sts,
    output tdpt_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_TEST   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_prime;
    logic       n_prime;

    assign o_s_tready = r_state == S_IDLE;

    always_comb begin
        n_state         = r_state;
        n_prime         = r_prime;
        o_cmd           = '0;
        o_cmd.res_value = r_prime;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.trivial) begin
                    n_prime = 1'b0;
                    n_state = S_FINISH;
                end else if (i_sts.bound_exceeded) begin
                    n_prime = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.rem_zero) begin
                    n_prime = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prime <= n_prime;
        end
    end

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_CHECK))
        else $error("accepted transaction did not start a check");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (r_state == S_FINISH) && i_sts.out_free)
        else $error("result loaded outside the finish state or into a full output");

    a_step_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_step |-> (r_state == S_DIV) && !o_cmd.div_start)
        else $error("division step outside the division state");

    a_div_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == S_DIV))
        else $error("division start did not enter the division state");

endmodule

// ===== hw/rtl/trial_division_prime_test.sv =====
// Values of 3 or less and negative values are decided without a division; otherwise
// each divisor tried from 2 upward, while its square does not exceed the value, is tested
// by the bit-serial remainder unit, one quotient bit per cycle, until one divides.
// One transaction is processed at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH,
    localparam int IN_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // Fields from bit 0: candidate (VALUE_WIDTH bits, signed), zero padding.
    input  logic [IN_W-1:0] s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // Fields from bit 0: is_prime (1 bit), zero padding.
    output logic [7:0]      m_axis_tdata
);

    tdpt_pkg::t_cmd w_cmd;
    tdpt_pkg::t_sts w_sts;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tdpt_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// ===== tb/sv/tb_trial_division_prime_test.sv =====
`timescale 1ns / 1ps

module tb_trial_division_prime_test;

    localparam int VW = tdpt_pkg::DEFAULT_VALUE_WIDTH;
    localparam int IN_W = ((VW + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 100;
    // The largest positive prime needs about 46341 divisors to be tried.
    localparam int unsigned STALL_LIMIT = 5_000_000;

    localparam logic [VW-1:0] DIRECTED_VALUES [24] = '{
        32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 32'd1, 32'd2,
        32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
        32'd97, 32'd121, 32'd65536, 32'd65521, 32'd1000003, 32'd1022117,
        32'h5555_5555, 32'h2AAA_AAAA, 32'h7FFF_FFFE, 32'h4000_0000, 32'd2147483646,
        32'h7FFF_FFFF
    };

    typedef struct {
        logic [VW-1:0] candidate;
        bit            verdict;
    } t_verdict;

    class prime_scoreboard;
        t_verdict    verdicts[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        static function bit is_prime_value(logic [VW-1:0] v);
            longint unsigned n;
            longint unsigned d;
            if (v[VW-1]) begin
                return 1'b0;
            end
            n = longint'(v);
            if (n <= 1) begin
                return 1'b0;
            end
            for (d = 2; d <= n / d; d++) begin
                if (n % d == 0) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_candidate(logic [VW-1:0] v);
            t_verdict entry;
            entry.candidate = v;
            entry.verdict = is_prime_value(v);
            verdicts.push_back(entry);
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_result(logic [7:0] data);
            t_verdict entry;
            if (verdicts.size() == 0) begin
                report($sformatf("result 0x%02h with no candidate pending", data));
            end else begin
                entry = verdicts.pop_front();
                if (data !== {7'b0, entry.verdict}) begin
                    report($sformatf("candidate %0d: expected is_prime %0b, got tdata 0x%02h",
                                     $signed(entry.candidate), entry.verdict, data));
                end
            end
        endtask
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [7:0]      m_axis_tdata;

    prime_scoreboard board;
    int              burst_left = 0;
    int unsigned     idle_cycles = 0;
    int unsigned     rx_cycle = 0;
    int              rx_mode = 0;

    trial_division_prime_test #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[5:0] == 6'd0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= (rx_cycle % 7) > 2;
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("trial_division_prime_test regression: fail");
            $finish;
        end
    end

    task automatic drive_candidate(input logic [VW-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(v);
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        board.note_candidate(v);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Large positive values are built with a small factor so the divisor loop ends early.
    function automatic logic [VW-1:0] random_candidate();
        int unsigned small_primes [6] = '{2, 3, 5, 7, 11, 13};
        int unsigned p;
        int unsigned k;
        logic [VW-1:0] v;
        case ($urandom_range(0, 9)) inside
            [0:3]: begin
                v = $urandom_range(0, 2000);
            end
            4: begin
                v = $urandom | 32'h8000_0000;
            end
            5, 6: begin
                p = small_primes[$urandom_range(0, 5)];
                k = $urandom_range(1, 32'h7FFF_FFFF / p);
                v = p * k;
            end
            7: begin
                v = $urandom_range(2000, 200000);
            end
            8: begin
                v = $urandom & ~32'd1;
            end
            default: begin
                p = $urandom_range(2, 300);
                v = p * p;
            end
        endcase
        return v;
    endfunction

    initial begin
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED_VALUES[i]) begin
            drive_candidate(DIRECTED_VALUES[i]);
        end
        drain_results();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            drive_candidate(random_candidate());
            if (i == RANDOM_ITEMS / 2) begin
                drain_results();
            end
        end
        drain_results();
        repeat (40) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("trial_division_prime_test regression: pass");
        end else begin
            $display("trial_division_prime_test regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_dp.sv
hw/rtl/tdpt_ctrl.sv
hw/rtl/trial_division_prime_test.sv
tb/sv/tb_trial_division_prime_test.sv
